// File: src/websocket_frame_deframer_assert.svh
// assertion macros for the deframer; only wsd_core includes them
// expects signals named clk and rst in the scope of each use
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define WSD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define WSD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSD_ASSERT_IMPL(name, ante, cons, msg)
`define WSD_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// File: src/wsd_pkg.sv
// shared types and constants of the websocket frame deframer
// no dependencies
package wsd_pkg;

  localparam int DATA_W = 8;
  localparam int OP_W = 4;
  localparam int EV_W = 3;
  localparam int FLEN_W = 21;
  localparam int MCAP_W = 13;
  localparam int LACC_W = 24;
  localparam int HCNT_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_CLOSE = 4'h8;
  localparam logic [OP_W-1:0] OP_PONG = 4'hA;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [FLEN_W-1:0] CTRL_MAX_LEN = 21'd125;

  localparam logic [EV_W-1:0] EV_BYTE = 3'd0;
  localparam logic [EV_W-1:0] EV_EMPTY = 3'd1;
  localparam logic [EV_W-1:0] EV_PONG = 3'd2;
  localparam logic [EV_W-1:0] EV_CLOSE = 3'd3;
  localparam logic [EV_W-1:0] EV_ERROR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MSG_CAP = 1'b1;

  localparam logic [FLEN_W-1:0] MAX_FRAME_RST = 21'd1048576;
  localparam logic [MCAP_W-1:0] MSG_CAP_RST = 13'd4096;

  typedef struct packed {
    logic [EV_W-1:0] ev;
    logic [DATA_W-1:0] payload;
    logic [OP_W-1:0] opcode;
    logic ctl;
    logic fe;
    logic me;
  } res_t;

endpackage

// File: src/wsd_core.sv
// frame state and per-byte decode: header gathering, length checks,
// unmasking and message tracking; uses wsd_pkg and the assertion header
`include "websocket_frame_deframer_assert.svh"

module wsd_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [wsd_pkg::DATA_W-1:0]      data,
  input  logic [wsd_pkg::FLEN_W-1:0]      max_frame_len,
  input  logic [wsd_pkg::MCAP_W-1:0]      msg_cap,
  output logic                            res_gen,
  output wsd_pkg::res_t                   res
);

  // control state
  logic [wsd_pkg::HCNT_W-1:0] hcount, hcount_next;
  logic                       hdr_done, hdr_done_next;
  logic [wsd_pkg::FLEN_W-1:0] frag, frag_next;
  logic [wsd_pkg::MCAP_W-1:0] msg_cnt, msg_cnt_next;
  logic                       msg_open, msg_open_next;
  logic [wsd_pkg::OP_W-1:0]   msg_op, msg_op_next;
  logic                       closed, closed_next;

  // header payload registers
  logic [wsd_pkg::OP_W-1:0]   op, op_next;
  logic                       fin, fin_next;
  logic                       mask, mask_next;
  logic [6:0]                 code, code_next;
  logic [wsd_pkg::LACC_W-1:0] len_acc, len_acc_next;
  logic                       ovf, ovf_next;
  logic [wsd_pkg::DATA_W-1:0] key [4];
  logic [wsd_pkg::DATA_W-1:0] key_next [4];

  logic [6:0]                 cur_code;
  logic                       cur_mask;
  logic [wsd_pkg::HCNT_W-1:0] base, need, hcount_inc, kofs;
  logic [1:0]                 kidx;
  logic [wsd_pkg::FLEN_W-1:0] len_new;
  logic                       big, oversize, ctl_big, zero;
  logic [wsd_pkg::FLEN_W:0]   frag_inc;
  logic                       pl_fe;
  logic [wsd_pkg::MCAP_W:0]   msg_inc;
  logic [wsd_pkg::OP_W-1:0]   mop;

  function automatic wsd_pkg::res_t err_res(input logic [wsd_pkg::OP_W-1:0] o);
    wsd_pkg::res_t r;
    r = '0;
    r.ev = wsd_pkg::EV_ERROR;
    r.opcode = o;
    r.ctl = o[3];
    return r;
  endfunction

  assign cur_code = (hcount == 4'd1) ? data[6:0] : code;
  assign cur_mask = (hcount == 4'd1) ? data[7] : mask;

  always_comb begin
    if (cur_code == wsd_pkg::LEN_CODE_16) begin
      base = 4'd4;
    end else if (cur_code == wsd_pkg::LEN_CODE_64) begin
      base = 4'd10;
    end else begin
      base = 4'd2;
    end
  end

  assign need = base + (cur_mask ? 4'd4 : 4'd0);
  assign hcount_inc = hcount + 4'd1;
  assign kofs = hcount - base;
  assign kidx = kofs[1:0];

  // length as it stands once the current header byte is in
  assign len_new = len_acc_next[wsd_pkg::FLEN_W-1:0];
  assign big = ovf_next | (|len_acc_next[wsd_pkg::LACC_W-1:wsd_pkg::FLEN_W]);
  assign oversize = big | (len_new > max_frame_len);
  assign ctl_big = big | (len_new > wsd_pkg::CTRL_MAX_LEN);
  assign zero = !big && (len_new == '0);

  assign frag_inc = {1'b0, frag} + 22'd1;
  assign pl_fe = frag_inc >= {1'b0, len_acc[wsd_pkg::FLEN_W-1:0]};
  assign msg_inc = {1'b0, msg_cnt} + 14'd1;
  assign mop = msg_open ? msg_op : op;

  always_comb begin
    hcount_next = hcount;
    hdr_done_next = hdr_done;
    frag_next = frag;
    msg_cnt_next = msg_cnt;
    msg_open_next = msg_open;
    msg_op_next = msg_op;
    closed_next = closed;
    op_next = op;
    fin_next = fin;
    mask_next = mask;
    code_next = code;
    len_acc_next = len_acc;
    ovf_next = ovf;
    key_next = key;
    res_gen = 1'b0;
    res = '0;

    if (step && !closed) begin
      if (!hdr_done) begin
        hcount_next = hcount_inc;
        if (hcount == 4'd0) begin
          op_next = data[3:0];
          fin_next = data[7];
        end else if (hcount == 4'd1) begin
          mask_next = data[7];
          code_next = data[6:0];
          ovf_next = 1'b0;
          len_acc_next = (data[6:0] < wsd_pkg::LEN_CODE_16) ? {17'd0, data[6:0]} : '0;
        end else if (hcount < base) begin
          // extended length, big endian; anything pushed out the top is sticky
          ovf_next = ovf | (|len_acc[wsd_pkg::LACC_W-1:16]);
          len_acc_next = {len_acc[15:0], data};
        end else begin
          key_next[kidx] = data;
        end

        if (hcount != 4'd0 && hcount_inc == need) begin
          res_gen = 1'b1;
          if (oversize) begin
            closed_next = 1'b1;
            res = err_res(op);
          end else if (op[3]) begin
            if (!fin || ctl_big) begin
              closed_next = 1'b1;
              res = err_res(op);
            end else if (op == wsd_pkg::OP_CLOSE) begin
              closed_next = 1'b1;
              res.ev = wsd_pkg::EV_CLOSE;
              res.opcode = wsd_pkg::OP_CLOSE;
              res.ctl = 1'b1;
            end else if (zero) begin
              hcount_next = '0;
              frag_next = '0;
              res.ev = (op == wsd_pkg::OP_PONG) ? wsd_pkg::EV_PONG : wsd_pkg::EV_EMPTY;
              res.opcode = op;
              res.ctl = 1'b1;
              res.fe = 1'b1;
              res.me = 1'b1;
            end else begin
              res_gen = 1'b0;
              hdr_done_next = 1'b1;
            end
          end else begin
            if (!msg_open) begin
              msg_open_next = 1'b1;
              msg_op_next = op;
              msg_cnt_next = '0;
            end
            if (zero) begin
              hcount_next = '0;
              frag_next = '0;
              if (fin) begin
                msg_open_next = 1'b0;
                msg_cnt_next = '0;
              end
              res.ev = wsd_pkg::EV_EMPTY;
              res.opcode = mop;
              res.fe = 1'b1;
              res.me = fin;
            end else begin
              res_gen = 1'b0;
              hdr_done_next = 1'b1;
            end
          end
        end
      end else begin
        if (op == wsd_pkg::OP_PONG) begin
          // pong payload is swallowed, one report at its end
          frag_next = frag_inc[wsd_pkg::FLEN_W-1:0];
          if (pl_fe) begin
            hcount_next = '0;
            frag_next = '0;
            hdr_done_next = 1'b0;
            res_gen = 1'b1;
            res.ev = wsd_pkg::EV_PONG;
            res.opcode = wsd_pkg::OP_PONG;
            res.ctl = 1'b1;
            res.fe = 1'b1;
            res.me = 1'b1;
          end
        end else if (!op[3] && (msg_inc > {1'b0, msg_cap})) begin
          res_gen = 1'b1;
          closed_next = 1'b1;
          res = err_res(op);
        end else begin
          if (!op[3]) begin
            msg_cnt_next = msg_inc[wsd_pkg::MCAP_W-1:0];
          end
          frag_next = frag_inc[wsd_pkg::FLEN_W-1:0];
          res_gen = 1'b1;
          res.ev = wsd_pkg::EV_BYTE;
          res.payload = data ^ (mask ? key[frag[1:0]] : 8'h00);
          res.opcode = op[3] ? op : msg_op;
          res.ctl = op[3];
          res.fe = pl_fe;
          res.me = pl_fe & fin;
          if (pl_fe) begin
            hcount_next = '0;
            frag_next = '0;
            hdr_done_next = 1'b0;
            if (!op[3] && fin) begin
              msg_open_next = 1'b0;
              msg_cnt_next = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcount <= '0;
      hdr_done <= 1'b0;
      frag <= '0;
      msg_cnt <= '0;
      msg_open <= 1'b0;
      msg_op <= '0;
      closed <= 1'b0;
    end else begin
      hcount <= hcount_next;
      hdr_done <= hdr_done_next;
      frag <= frag_next;
      msg_cnt <= msg_cnt_next;
      msg_open <= msg_open_next;
      msg_op <= msg_op_next;
      closed <= closed_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    fin <= fin_next;
    mask <= mask_next;
    code <= code_next;
    len_acc <= len_acc_next;
    ovf <= ovf_next;
    key <= key_next;
  end

  `WSD_ASSERT_NEXT(a_closed_sticky, closed, closed, "closed state left without reset")
  `WSD_ASSERT_NEXT(a_error_closes,
    step && res_gen && (res.ev == wsd_pkg::EV_ERROR || res.ev == wsd_pkg::EV_CLOSE),
    closed, "error or close did not close the block")
  `WSD_ASSERT_IMPL(a_frag_in_frame, hdr_done,
    frag < len_acc[wsd_pkg::FLEN_W-1:0], "payload count ran past frame length")
  `WSD_ASSERT_NEXT(a_frame_end_clears, step && res_gen && res.fe,
    frag == '0 && hcount == '0 && !hdr_done, "frame end did not clear frame state")

endmodule

// File: src/wsd_out_reg.sv
// result register that parts the decode stage from the receiver
// uses wsd_pkg for the result type
module wsd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  wsd_pkg::res_t res,
  input  logic          result_ready,
  output logic          adv,
  output logic          result_valid,
  output wsd_pkg::res_t out_res
);

  // the stage ahead may move when this register is empty or being drained
  assign adv = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// File: src/websocket_frame_deframer.sv
// websocket frame deframer: byte stream in, unmasked payload and events out
// top level; uses wsd_pkg, wsd_core and wsd_out_reg
//
// data channel: one stream byte per transfer on data_valid / data_ready.
// result channel: at most one result per byte on result_valid / result_ready,
// carrying event_res, payload, opcode, is_control, frame_end, message_end.
// cfg channel: cfg_index selects max_frame_length (0) or message_capacity (1),
// always ready; write only while the block is idle.
// path: a byte taken in passes the input register and decode, and its result,
// if any, is then held in the result register that drives result_valid.
// throughput: one byte per cycle unless stalled; the input register and the
// result register each hold one item, and decode is a single pass between
// them. a stalled receiver holds the result register; one more byte can sit
// in the input register, then data_ready drops until the result is taken.
// reset clears frame and message state, the closed flag and both registers,
// and loads max_frame_length 1048576 and message_capacity 4096.
// after a close frame or a protocol error no further results appear until
// reset.
module websocket_frame_deframer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         data_valid,
  output logic                         data_ready,
  input  logic [wsd_pkg::DATA_W-1:0]   data_byte,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsd_pkg::FLEN_W-1:0]   cfg_data,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [wsd_pkg::EV_W-1:0]     event_res,
  output logic [wsd_pkg::DATA_W-1:0]   payload,
  output logic [wsd_pkg::OP_W-1:0]     opcode,
  output logic                         is_control,
  output logic                         frame_end,
  output logic                         message_end
);

  logic [wsd_pkg::FLEN_W-1:0] max_frame_len;
  logic [wsd_pkg::MCAP_W-1:0] msg_cap;
  logic                       in_valid;
  logic [wsd_pkg::DATA_W-1:0] in_byte;
  logic                       adv;
  logic                       step;
  logic                       res_gen;
  wsd_pkg::res_t              res;
  wsd_pkg::res_t              out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= wsd_pkg::MAX_FRAME_RST;
      msg_cap <= wsd_pkg::MSG_CAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsd_pkg::REG_MAX_FRAME: max_frame_len <= cfg_data;
        wsd_pkg::REG_MSG_CAP:   msg_cap <= cfg_data[wsd_pkg::MCAP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign step = in_valid && adv;
  assign data_ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (data_ready) begin
      in_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      in_byte <= data_byte;
    end
  end

  wsd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data          (in_byte),
    .max_frame_len (max_frame_len),
    .msg_cap       (msg_cap),
    .res_gen       (res_gen),
    .res           (res)
  );

  wsd_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (step && res_gen),
    .res          (res),
    .result_ready (result_ready),
    .adv          (adv),
    .result_valid (result_valid),
    .out_res      (out_res)
  );

  assign event_res = out_res.ev;
  assign payload = out_res.payload;
  assign opcode = out_res.opcode;
  assign is_control = out_res.ctl;
  assign frame_end = out_res.fe;
  assign message_end = out_res.me;

endmodule
